/* rtl/core/hsl_pkg.sv */
// ----------------------------------------------------------------------------
// hsl_pkg
// shared types, constants and sector helpers of the hsl to rgb color unit
// ----------------------------------------------------------------------------
package hsl_pkg;

  // pixel addressing
  localparam int PIXEL_COUNT = 16;
  localparam int PIX_IDX_W   = 4;

  // input ranges
  localparam int HUE_FULL    = 360;
  localparam int HUE_THIRD   = 120;
  localparam int HUE_FALL    = 240;
  localparam int HUE_HIGH    = 180;
  localparam int SECTOR_DEG  = 60;
  localparam int PCT_MAX     = 100;
  localparam int PCT_HALF    = 50;
  localparam int PCT_DOUBLE  = 200;

  // level = floor(num * 255 / 600000) = floor((num * 17 >> 6) / 625)
  // the divide by 625 is a reciprocal multiply, exact for the 18-bit range
  localparam int LEVEL_MUL    = 17;
  localparam int LEVEL_PRESH  = 6;
  localparam int LEVEL_SHIFT  = 28;
  localparam int LEVEL_RECIP  = 429497;
  localparam int LEVEL_MAX    = 255;

  // internal widths
  localparam int PCT_W    = 7;
  localparam int WEIGHT_W = 6;
  localparam int FRAC_W   = 14;
  localparam int NUM_W    = 20;
  localparam int SCALED_W = 24;
  localparam int QUOT_W   = SCALED_W - LEVEL_PRESH;
  localparam int RECIP_W  = 19;
  localparam int PROD_W   = QUOT_W + RECIP_W;
  localparam int LVL_W    = PROD_W - LEVEL_SHIFT;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [4:0] pixel_number;
    logic [8:0] hue_degrees;
    logic [6:0] saturation_pct;
    logic [6:0] lightness_pct;
  } hsl_in_t;

  typedef struct packed {
    logic [3:0]  pixel_index;
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [11:0] packed_color;
  } hsl_out_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [PCT_W-1:0]     saturation;
    logic [PCT_W-1:0]     lightness;
    logic                 light_hi;
    logic [WEIGHT_W-1:0]  w_red;
    logic [WEIGHT_W-1:0]  w_green;
    logic [WEIGHT_W-1:0]  w_blue;
  } hsl_cls_t;

  typedef enum logic [1:0] {
    SEC_RISE,
    SEC_HIGH,
    SEC_FALL,
    SEC_LOW
  } hsl_sector_e;

  function automatic hsl_sector_e sector_of(logic [8:0] t);
    hsl_sector_e s;
    if (t < 9'(SECTOR_DEG)) begin
      s = SEC_RISE;
    end else if (t < 9'(HUE_HIGH)) begin
      s = SEC_HIGH;
    end else if (t < 9'(HUE_FALL)) begin
      s = SEC_FALL;
    end else begin
      s = SEC_LOW;
    end
    return s;
  endfunction

  // weight of (q - p) in the channel value p * 60 + (q - p) * w
  function automatic logic [WEIGHT_W-1:0] sector_weight(logic [8:0] t);
    logic [8:0]          fall;
    logic [WEIGHT_W-1:0] w;
    fall = 9'(HUE_FALL) - t;
    unique case (sector_of(t))
      SEC_RISE: w = t[WEIGHT_W-1:0];
      SEC_HIGH: w = WEIGHT_W'(SECTOR_DEG);
      SEC_FALL: w = fall[WEIGHT_W-1:0];
      SEC_LOW:  w = '0;
      default:  w = '0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/hsl_front.sv */
// ----------------------------------------------------------------------------
// hsl_front
// clamps the input word and works out the hue sector weights per channel
// ----------------------------------------------------------------------------
module hsl_front (
  input  hsl_pkg::hsl_in_t  in_word_i,
  output hsl_pkg::hsl_cls_t cls_o
);

  logic [4:0] num_m1;
  logic [8:0] hue;
  logic [9:0] t_red_sum;
  logic [8:0] t_red;
  logic [8:0] t_blue;
  logic [6:0] sat;
  logic [6:0] lig;

  always_comb begin
    // pixel index: number minus one, saturated to the last pixel
    num_m1 = (in_word_i.pixel_number == '0) ? 5'd0 : in_word_i.pixel_number - 5'd1;
    if (32'(num_m1) > hsl_pkg::PIXEL_COUNT - 1) begin
      cls_o.pixel_index = hsl_pkg::PIX_IDX_W'(hsl_pkg::PIXEL_COUNT - 1);
    end else begin
      cls_o.pixel_index = num_m1[hsl_pkg::PIX_IDX_W-1:0];
    end

    // hue wraps once
    hue = (in_word_i.hue_degrees >= 9'(hsl_pkg::HUE_FULL)) ?
          in_word_i.hue_degrees - 9'(hsl_pkg::HUE_FULL) : in_word_i.hue_degrees;

    sat = (in_word_i.saturation_pct > 7'(hsl_pkg::PCT_MAX)) ?
          7'(hsl_pkg::PCT_MAX) : in_word_i.saturation_pct;
    lig = (in_word_i.lightness_pct > 7'(hsl_pkg::PCT_MAX)) ?
          7'(hsl_pkg::PCT_MAX) : in_word_i.lightness_pct;

    // red leads by a third of a turn, blue lags by a third
    t_red_sum = 10'(hue) + 10'(hsl_pkg::HUE_THIRD);
    t_red = (t_red_sum >= 10'(hsl_pkg::HUE_FULL)) ?
            9'(t_red_sum - 10'(hsl_pkg::HUE_FULL)) : t_red_sum[8:0];
    t_blue = (hue < 9'(hsl_pkg::HUE_THIRD)) ? hue + 9'(hsl_pkg::HUE_FALL) :
             hue - 9'(hsl_pkg::HUE_THIRD);

    cls_o.saturation = sat;
    cls_o.lightness  = lig;
    cls_o.light_hi   = (lig >= 7'(hsl_pkg::PCT_HALF));
    cls_o.w_red      = hsl_pkg::sector_weight(t_red);
    cls_o.w_green    = hsl_pkg::sector_weight(hue);
    cls_o.w_blue     = hsl_pkg::sector_weight(t_blue);
  end

endmodule

/* rtl/core/hsl_queue.sv */
// ----------------------------------------------------------------------------
// hsl_queue
// short register queue between the classifier and the arithmetic pipeline
// ----------------------------------------------------------------------------
module hsl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hsl_pkg::hsl_cls_t word_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output hsl_pkg::hsl_cls_t word_o
);

  hsl_pkg::hsl_cls_t mem_q [hsl_pkg::QUEUE_DEPTH];
  logic [hsl_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [hsl_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [hsl_pkg::QUEUE_PTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (hsl_pkg::QUEUE_PTR_W+1)'(hsl_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign word_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == hsl_pkg::QUEUE_PTR_W'(hsl_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == hsl_pkg::QUEUE_PTR_W'(hsl_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

/* rtl/core/hsl_back.sv */
// ----------------------------------------------------------------------------
// hsl_back
// four stage pipeline: q/p, channel numerators, scaling, clamp and pack
// ----------------------------------------------------------------------------
module hsl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cls_valid_i,
  input  hsl_pkg::hsl_cls_t cls_i,
  output logic              cls_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hsl_pkg::hsl_out_t out_word_o
);

  localparam int FW = hsl_pkg::FRAC_W;
  localparam int NW = hsl_pkg::NUM_W;
  localparam int LW = hsl_pkg::LVL_W;
  localparam int WW = hsl_pkg::WEIGHT_W;

  logic v1_q, v2_q, v3_q, out_valid_q;
  logic adv1, adv2, adv3, adv_out;

  // stage 1
  logic [3:0]    idx1_q;
  logic [FW-1:0] p1_q, d1_q;
  logic [WW-1:0] wr1_q, wg1_q, wb1_q;
  // stage 2
  logic [3:0]    idx2_q;
  logic [NW-1:0] nr2_q, ng2_q, nb2_q;
  // stage 3
  logic [3:0]    idx3_q;
  logic [LW-1:0] lr3_q, lg3_q, lb3_q;

  hsl_pkg::hsl_out_t out_q;

  logic [FW-1:0] ls_prod;
  logic [14:0]   q_lo, q_hi, q15, p15;
  logic [NW-1:0] nr_d, ng_d, nb_d;
  logic [LW-1:0] lr_d, lg_d, lb_d;
  logic [7:0]    r_c, g_c, b_c;

  assign adv_out   = !out_valid_q || !out_stall_i;
  assign adv3      = !v3_q || adv_out;
  assign adv2      = !v2_q || adv3;
  assign adv1      = !v1_q || adv2;
  assign cls_pop_o = cls_valid_i && adv1;

  function automatic logic [NW-1:0] chan_num(logic [FW-1:0] p, logic [FW-1:0] d,
                                             logic [WW-1:0] w);
    logic [NW:0] s;
    s = (NW+1)'(p) * (NW+1)'(hsl_pkg::SECTOR_DEG) + (NW+1)'(d) * (NW+1)'(w);
    return s[NW-1:0];
  endfunction

  function automatic logic [LW-1:0] chan_level(logic [NW-1:0] n);
    logic [hsl_pkg::SCALED_W-1:0] x;
    logic [hsl_pkg::QUOT_W-1:0]   y;
    logic [hsl_pkg::PROD_W-1:0]   prod;
    // times 17 as shift and add
    x = {n, 4'b0000} + hsl_pkg::SCALED_W'(n);
    y = x[hsl_pkg::SCALED_W-1:hsl_pkg::LEVEL_PRESH];
    prod = hsl_pkg::PROD_W'(y) * hsl_pkg::PROD_W'(hsl_pkg::LEVEL_RECIP);
    return prod[hsl_pkg::LEVEL_SHIFT +: LW];
  endfunction

  function automatic logic [7:0] clamp8(logic [LW-1:0] l);
    return (l > LW'(hsl_pkg::LEVEL_MAX)) ? 8'hFF : l[7:0];
  endfunction

  always_comb begin
    ls_prod = FW'(cls_i.lightness) * FW'(cls_i.saturation);
    q_lo = 15'(cls_i.lightness) * (15'(hsl_pkg::PCT_MAX) + 15'(cls_i.saturation));
    q_hi = 15'(hsl_pkg::PCT_MAX) * 15'(cls_i.lightness)
         + 15'(hsl_pkg::PCT_MAX) * 15'(cls_i.saturation) - 15'(ls_prod);
    q15  = cls_i.light_hi ? q_hi : q_lo;
    p15  = 15'(hsl_pkg::PCT_DOUBLE) * 15'(cls_i.lightness) - q15;

    nr_d = chan_num(p1_q, d1_q, wr1_q);
    ng_d = chan_num(p1_q, d1_q, wg1_q);
    nb_d = chan_num(p1_q, d1_q, wb1_q);

    lr_d = chan_level(nr2_q);
    lg_d = chan_level(ng2_q);
    lb_d = chan_level(nb2_q);

    r_c = clamp8(lr3_q);
    g_c = clamp8(lg3_q);
    b_c = clamp8(lb3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= cls_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
      if (adv_out) begin
        out_valid_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      idx1_q <= cls_i.pixel_index;
      p1_q   <= p15[FW-1:0];
      d1_q   <= q15[FW-1:0] - p15[FW-1:0];
      wr1_q  <= cls_i.w_red;
      wg1_q  <= cls_i.w_green;
      wb1_q  <= cls_i.w_blue;
    end
    if (adv2) begin
      idx2_q <= idx1_q;
      nr2_q  <= nr_d;
      ng2_q  <= ng_d;
      nb2_q  <= nb_d;
    end
    if (adv3) begin
      idx3_q <= idx2_q;
      lr3_q  <= lr_d;
      lg3_q  <= lg_d;
      lb3_q  <= lb_d;
    end
    if (adv_out) begin
      out_q.pixel_index  <= idx3_q;
      out_q.red_level    <= r_c;
      out_q.green_level  <= g_c;
      out_q.blue_level   <= b_c;
      out_q.packed_color <= {r_c[7:4], g_c[7:4], b_c[7:4]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* rtl/core/hsl_to_rgb_pixel_color_unit.sv */
// ----------------------------------------------------------------------------
// hsl_to_rgb_pixel_color_unit
// hsl to 8-bit rgb pixel color converter with 12-bit 4:4:4 packed output
// ----------------------------------------------------------------------------
// takes one word per clock while in_stall_o is low and gives one result word
// per input word, in order. a word is accepted when in_valid_i is high and
// in_stall_o low; the front classifier clamps saturation and lightness to
// 100, wraps the hue once at 360, saturates the pixel index and picks each
// channel's hue sector, all in the accept cycle, and writes the word into a
// four-entry queue. the back pipeline pops one word per clock while its
// first stage can advance and takes four stages (q and p, channel numerators,
// reciprocal scaling to floor(255 * fraction), clamp and pack). throughput
// is one word per cycle unless the output stalls, set by the single issue
// slot of each back stage. in_stall_o rises only when the queue is full,
// which happens after the output has been stalled long enough to back up
// the pipeline; the queue lets the front keep accepting meanwhile.
module hsl_to_rgb_pixel_color_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hsl_pkg::hsl_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hsl_pkg::hsl_out_t out_word_o
);

  hsl_pkg::hsl_cls_t cls_in, cls_out;
  logic q_full, q_valid, q_pop, q_push;

  // accept whenever the queue has room
  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  hsl_front u_front (
    .in_word_i (in_word_i),
    .cls_o     (cls_in)
  );

  hsl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .word_i  (cls_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .word_o  (cls_out)
  );

  // arithmetic pipeline, ends in the output register
  hsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (q_valid),
    .cls_i       (cls_out),
    .cls_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* rtl/core/hsl_checker.sv */
// ----------------------------------------------------------------------------
// hsl_checker
// port level checks of the hsl to rgb color unit, bound to the top level
// ----------------------------------------------------------------------------
module hsl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input hsl_pkg::hsl_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input hsl_pkg::hsl_out_t out_word_o
);

  // reset empties the pipeline
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result word shown during reset");

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // packed color is the top nibble of each channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.packed_color == {out_word_o.red_level[7:4],
                    out_word_o.green_level[7:4], out_word_o.blue_level[7:4]})
    else $error("packed color does not match channels");

  // the queue only fills by taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted word");

  // word payload is watched only through the handshake
  logic unused_in;
  assign unused_in = ^in_word_i;

endmodule

bind hsl_to_rgb_pixel_color_unit hsl_checker u_checker (.*);
